// ===== rtl/core/llcp_pkg.sv =====
// Shared types, widths and codes of the line-to-line closest point pipeline.
`default_nettype none

package llcp_pkg;

    localparam int CRD_W     = 32;    // Q16.16 coordinate
    localparam int DIF_W     = 33;    // coordinate difference
    localparam int DOT_W     = 68;    // three-term dot product
    localparam int NUM_W     = 136;   // denominator and numerators
    localparam int PRD_W     = 170;   // numerator times difference
    localparam int NUM_DIV_W = 172;   // dividend fed to a divider
    localparam int DEN_DIV_W = 136;   // divisor fed to a divider
    localparam int QUO_W     = 34;    // quotient bits kept before saturation
    localparam int EPS_W     = 16;
    localparam int CFG_IDX_W = 8;
    localparam int DEN_EPS_SHIFT = 48;

    localparam logic [EPS_W-1:0] EPS_RESET = 16'd7;

    localparam logic [CFG_IDX_W-1:0] CFG_COORD_EPS = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DENOM_EPS = 8'd1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_B_DEGEN  = 2'd1;
    localparam logic [1:0] ST_A_DEGEN  = 2'd2;
    localparam logic [1:0] ST_PARALLEL = 2'd3;

    typedef struct packed {
        logic signed [CRD_W-1:0] first_start_x;
        logic signed [CRD_W-1:0] first_start_y;
        logic signed [CRD_W-1:0] first_start_z;
        logic signed [CRD_W-1:0] first_end_x;
        logic signed [CRD_W-1:0] first_end_y;
        logic signed [CRD_W-1:0] first_end_z;
        logic signed [CRD_W-1:0] second_start_x;
        logic signed [CRD_W-1:0] second_start_y;
        logic signed [CRD_W-1:0] second_start_z;
        logic signed [CRD_W-1:0] second_end_x;
        logic signed [CRD_W-1:0] second_end_y;
        logic signed [CRD_W-1:0] second_end_z;
    } item_t;

    typedef struct packed {
        logic [1:0]              status;
        logic signed [CRD_W-1:0] near_a_x;
        logic signed [CRD_W-1:0] near_a_y;
        logic signed [CRD_W-1:0] near_a_z;
        logic signed [CRD_W-1:0] near_b_x;
        logic signed [CRD_W-1:0] near_b_y;
        logic signed [CRD_W-1:0] near_b_z;
        logic signed [CRD_W-1:0] param_a;
        logic signed [CRD_W-1:0] param_b;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/core/line_line_closest_points.sv =====
// Top level: closest points between two 3D lines, fully pipelined.
// done is registered alongside the result, so both change at the same edge.
// Throughput: one line pair per cycle; busy stays low.
// The 34 quotient-bit stages of the eight shared-divisor dividers set the depth.
// Reset (rst_n low, asynchronous) clears all valid bits and loads both epsilon
// registers with 7; results in flight are dropped. The receiver cannot stall.
`default_nettype none

module line_line_closest_points
    import llcp_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire item_t                item,
    output logic                      done,
    output result_t                   result,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [EPS_W-1:0]     cfg_data
);

    localparam int DIV_LAT    = QUO_W + 1;
    localparam int SIDE_LAST  = 13 + DIV_LAT;
    localparam int LATENCY    = 15 + DIV_LAT;
    localparam int HW         = DOT_W / 2;      // half of a dot magnitude
    localparam int CH         = NUM_W / 4;      // chunk of a numerator magnitude
    localparam int MP_W       = CH + DIF_W;
    localparam int SUM_W      = QUO_W + 2;

    // dot product slots
    localparam int D1343 = 0;
    localparam int D4321 = 1;
    localparam int D1321 = 2;
    localparam int D4343 = 3;
    localparam int D2121 = 4;

    // operand pairs: denom = p0 - p1, na = p2 - p3, nb = p4 - p5
    localparam int PA [6] = '{D2121, D4321, D1343, D1321, D1343, D4321};
    localparam int PB [6] = '{D4343, D4321, D4321, D4343, D2121, D1321};

    localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'($signed(32'h7FFF_FFFF));
    localparam logic signed [SUM_W-1:0] SUM_MIN = SUM_W'($signed(32'h8000_0000));
    localparam logic [CRD_W-1:0]        SAT_MAX = 32'h7FFF_FFFF;
    localparam logic [CRD_W-1:0]        SAT_MIN = 32'h8000_0000;

    // Items ride next to the arithmetic with this record: bases for the final
    // add, direction magnitudes, signs and the status code built up on the way.
    typedef struct packed {
        logic [1:0]                  status;
        logic [2:0][CRD_W-1:0]       base_a;
        logic [2:0][CRD_W-1:0]       base_b;
        logic [2:0][DIF_W-1:0]       mag21;
        logic [2:0][DIF_W-1:0]       mag43;
        logic [2:0]                  neg21;
        logic [2:0]                  neg43;
        logic [7:0]                  qneg;
    } side_t;

    // configuration
    logic [EPS_W-1:0] coord_eps_reg;
    logic [EPS_W-1:0] denom_eps_reg;

    // valid bits of stages 0 to 13
    logic [13:0] vld_reg;

    item_t                       item_reg;
    logic signed [DIF_W-1:0]     p13_reg [3];
    logic signed [DIF_W-1:0]     p43_reg [3];
    logic signed [DIF_W-1:0]     p21_reg [3];
    logic signed [2*DIF_W-1:0]   prod_reg [5][3];
    logic signed [DOT_W-1:0]     dot_reg [5];
    logic [DOT_W-1:0]            dmag_reg [5];
    logic                        dneg_reg [5];
    logic [2*HW-1:0]             pp_reg [6][4];
    logic                        pneg_reg [6];
    logic                        pneg6_reg [6];
    logic [NUM_W-1:0]            pmag_reg [6];
    logic signed [NUM_W-1:0]     pval_reg [6];
    logic signed [NUM_W-1:0]     w_reg [3];
    logic [NUM_W-1:0]            wmag_reg [3];
    logic                        wneg_reg [3];
    logic [MP_W-1:0]             mp_reg [6][4];
    logic [NUM_W-1:0]            nm10_reg [3];
    logic [NUM_W-1:0]            nm11_reg [3];
    logic [PRD_W-1:0]            lo_reg [6];
    logic [PRD_W-1:0]            hi_reg [6];
    logic [PRD_W-1:0]            prd_reg [8];
    logic [NUM_W-1:0]            dm12_reg;
    logic [NUM_DIV_W-1:0]        num_reg [8];
    logic [DEN_DIV_W-1:0]        den13_reg;
    side_t                       side_reg [1:SIDE_LAST];

    logic signed [CRD_W-1:0]     p1c [3];
    logic signed [CRD_W-1:0]     p2c [3];
    logic signed [CRD_W-1:0]     p3c [3];
    logic signed [CRD_W-1:0]     p4c [3];
    logic signed [DIF_W:0]       ceps;
    logic                        small43;
    logic                        small21;
    logic                        par;
    logic [NUM_W-1:0]            thr;

    logic [7:0]                  div_valid;
    logic [QUO_W-1:0]            div_quo [8];
    logic [7:0]                  div_ovf;

    logic                        done_reg;
    result_t                     result_reg;
    result_t                     result_next;
    logic [CRD_W-1:0]            fin [8];

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    // ---------------------------------------------------------------------
    // Configuration: registers beyond the list are ignored
    // ---------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coord_eps_reg <= EPS_RESET;
            denom_eps_reg <= EPS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_COORD_EPS: coord_eps_reg <= cfg_data;
                CFG_DENOM_EPS: denom_eps_reg <= cfg_data;
                default:       ;
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // Valid line: the pipeline never stalls, so valid bits just advance
    // ---------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            vld_reg  <= {vld_reg[12:0], start && !busy};
            done_reg <= div_valid[0];
        end
    end

    // coordinate views of the input register
    always_comb
    begin
        p1c[0] = item_reg.first_start_x;
        p1c[1] = item_reg.first_start_y;
        p1c[2] = item_reg.first_start_z;
        p2c[0] = item_reg.first_end_x;
        p2c[1] = item_reg.first_end_y;
        p2c[2] = item_reg.first_end_z;
        p3c[0] = item_reg.second_start_x;
        p3c[1] = item_reg.second_start_y;
        p3c[2] = item_reg.second_start_z;
        p4c[0] = item_reg.second_end_x;
        p4c[1] = item_reg.second_end_y;
        p4c[2] = item_reg.second_end_z;
    end

    // A direction is degenerate when every component lies strictly inside
    // (-eps, eps); the second line is checked first.
    always_comb
    begin
        ceps    = (DIF_W+1)'(coord_eps_reg);
        small43 = 1'b1;
        small21 = 1'b1;
        for (int i = 0; i < 3; i++)
        begin
            small43 = small43 && (p43_reg[i] < ceps) && (p43_reg[i] > -ceps);
            small21 = small21 && (p21_reg[i] < ceps) && (p21_reg[i] > -ceps);
        end
    end

    // Parallel when |denom| is zero or below denom_epsilon scaled to fourth order.
    always_comb
    begin
        thr = NUM_W'(denom_eps_reg) << DEN_EPS_SHIFT;
        par = (wmag_reg[0] == '0) || (wmag_reg[0] < thr);
    end

    // ---------------------------------------------------------------------
    // Arithmetic stages (payload, no reset)
    // ---------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        // stage 0: capture the transfer
        item_reg <= item;

        // stage 1: direction and offset vectors
        for (int i = 0; i < 3; i++)
        begin
            p13_reg[i] <= DIF_W'(p1c[i]) - DIF_W'(p3c[i]);
            p43_reg[i] <= DIF_W'(p4c[i]) - DIF_W'(p3c[i]);
            p21_reg[i] <= DIF_W'(p2c[i]) - DIF_W'(p1c[i]);
        end

        // stage 2: component products of the five dot products
        for (int i = 0; i < 3; i++)
        begin
            prod_reg[D1343][i] <= (2*DIF_W)'(p13_reg[i]) * (2*DIF_W)'(p43_reg[i]);
            prod_reg[D4321][i] <= (2*DIF_W)'(p43_reg[i]) * (2*DIF_W)'(p21_reg[i]);
            prod_reg[D1321][i] <= (2*DIF_W)'(p13_reg[i]) * (2*DIF_W)'(p21_reg[i]);
            prod_reg[D4343][i] <= (2*DIF_W)'(p43_reg[i]) * (2*DIF_W)'(p43_reg[i]);
            prod_reg[D2121][i] <= (2*DIF_W)'(p21_reg[i]) * (2*DIF_W)'(p21_reg[i]);
        end

        // stage 3: dot products
        for (int k = 0; k < 5; k++)
        begin
            dot_reg[k] <= DOT_W'(prod_reg[k][0]) + DOT_W'(prod_reg[k][1])
                        + DOT_W'(prod_reg[k][2]);
        end

        // stage 4: sign and magnitude of each dot product
        for (int k = 0; k < 5; k++)
        begin
            dneg_reg[k] <= dot_reg[k][DOT_W-1];
            dmag_reg[k] <= dot_reg[k][DOT_W-1] ? DOT_W'(-dot_reg[k]) : DOT_W'(dot_reg[k]);
        end

        // stage 5: half-by-half partial products of the six dot products pairs
        for (int m = 0; m < 6; m++)
        begin
            pp_reg[m][0] <= (2*HW)'(dmag_reg[PA[m]][HW-1:0])
                          * (2*HW)'(dmag_reg[PB[m]][HW-1:0]);
            pp_reg[m][1] <= (2*HW)'(dmag_reg[PA[m]][HW-1:0])
                          * (2*HW)'(dmag_reg[PB[m]][2*HW-1:HW]);
            pp_reg[m][2] <= (2*HW)'(dmag_reg[PA[m]][2*HW-1:HW])
                          * (2*HW)'(dmag_reg[PB[m]][HW-1:0]);
            pp_reg[m][3] <= (2*HW)'(dmag_reg[PA[m]][2*HW-1:HW])
                          * (2*HW)'(dmag_reg[PB[m]][2*HW-1:HW]);
            pneg_reg[m]  <= dneg_reg[PA[m]] ^ dneg_reg[PB[m]];
        end

        // stage 6: product magnitudes
        for (int m = 0; m < 6; m++)
        begin
            pmag_reg[m]  <= NUM_W'(pp_reg[m][0])
                          + ((NUM_W'(pp_reg[m][1]) + NUM_W'(pp_reg[m][2])) << HW)
                          + (NUM_W'(pp_reg[m][3]) << (2*HW));
            pneg6_reg[m] <= pneg_reg[m];
        end

        // stage 7: signed products
        for (int m = 0; m < 6; m++)
        begin
            pval_reg[m] <= pneg6_reg[m] ? -$signed(pmag_reg[m]) : $signed(pmag_reg[m]);
        end

        // stage 8: denom, na, nb
        for (int n = 0; n < 3; n++)
        begin
            w_reg[n] <= pval_reg[2*n] - pval_reg[2*n+1];
        end

        // stage 9: sign and magnitude
        for (int n = 0; n < 3; n++)
        begin
            wneg_reg[n] <= w_reg[n][NUM_W-1];
            wmag_reg[n] <= w_reg[n][NUM_W-1] ? NUM_W'(-w_reg[n]) : NUM_W'(w_reg[n]);
        end

        // stage 10: chunked products |na| * |p21|, |nb| * |p43|
        for (int i = 0; i < 3; i++)
        begin
            for (int c = 0; c < 4; c++)
            begin
                mp_reg[i][c]   <= MP_W'(wmag_reg[1][c*CH +: CH])
                                * MP_W'(side_reg[9].mag21[i]);
                mp_reg[3+i][c] <= MP_W'(wmag_reg[2][c*CH +: CH])
                                * MP_W'(side_reg[9].mag43[i]);
            end
        end
        for (int n = 0; n < 3; n++)
        begin
            nm10_reg[n] <= wmag_reg[n];
            nm11_reg[n] <= nm10_reg[n];
        end

        // stage 11: pair sums of the chunks
        for (int m = 0; m < 6; m++)
        begin
            lo_reg[m] <= PRD_W'(mp_reg[m][0]) + (PRD_W'(mp_reg[m][1]) << CH);
            hi_reg[m] <= PRD_W'(mp_reg[m][2]) + (PRD_W'(mp_reg[m][3]) << CH);
        end

        // stage 12: full dividend magnitudes, params scaled by 2^16
        for (int m = 0; m < 6; m++)
        begin
            prd_reg[m] <= lo_reg[m] + (hi_reg[m] << (2*CH));
        end
        prd_reg[6] <= PRD_W'(nm11_reg[1]) << 16;
        prd_reg[7] <= PRD_W'(nm11_reg[2]) << 16;
        dm12_reg   <= nm11_reg[0];

        // stage 13: round to nearest, ties away: (2|n| + |d|) / (2|d|)
        for (int q = 0; q < 8; q++)
        begin
            num_reg[q] <= (NUM_DIV_W'(prd_reg[q]) << 1) + NUM_DIV_W'(dm12_reg);
        end
        den13_reg <= DEN_DIV_W'(dm12_reg) << 1;
    end

    // ---------------------------------------------------------------------
    // Side record: advance every cycle, fill in at stages 1, 2 and 10
    // ---------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        for (int k = 3; k <= SIDE_LAST; k++)
        begin
            if (k != 10)
            begin
                side_reg[k] <= side_reg[k-1];
            end
        end

        side_reg[1].status <= ST_OK;
        side_reg[1].mag21  <= '0;
        side_reg[1].mag43  <= '0;
        side_reg[1].neg21  <= '0;
        side_reg[1].neg43  <= '0;
        side_reg[1].qneg   <= '0;
        for (int i = 0; i < 3; i++)
        begin
            side_reg[1].base_a[i] <= p1c[i];
            side_reg[1].base_b[i] <= p3c[i];
        end

        side_reg[2].base_a <= side_reg[1].base_a;
        side_reg[2].base_b <= side_reg[1].base_b;
        side_reg[2].qneg   <= side_reg[1].qneg;
        for (int i = 0; i < 3; i++)
        begin
            side_reg[2].neg21[i] <= p21_reg[i][DIF_W-1];
            side_reg[2].neg43[i] <= p43_reg[i][DIF_W-1];
            side_reg[2].mag21[i] <= p21_reg[i][DIF_W-1] ? DIF_W'(-p21_reg[i])
                                                        : DIF_W'(p21_reg[i]);
            side_reg[2].mag43[i] <= p43_reg[i][DIF_W-1] ? DIF_W'(-p43_reg[i])
                                                        : DIF_W'(p43_reg[i]);
        end
        if (small43)
        begin
            side_reg[2].status <= ST_B_DEGEN;
        end
        else if (small21)
        begin
            side_reg[2].status <= ST_A_DEGEN;
        end
        else
        begin
            side_reg[2].status <= ST_OK;
        end

        side_reg[10].base_a <= side_reg[9].base_a;
        side_reg[10].base_b <= side_reg[9].base_b;
        side_reg[10].mag21  <= side_reg[9].mag21;
        side_reg[10].mag43  <= side_reg[9].mag43;
        side_reg[10].neg21  <= side_reg[9].neg21;
        side_reg[10].neg43  <= side_reg[9].neg43;
        if (side_reg[9].status == ST_OK && par)
        begin
            side_reg[10].status <= ST_PARALLEL;
        end
        else
        begin
            side_reg[10].status <= side_reg[9].status;
        end
        for (int i = 0; i < 3; i++)
        begin
            side_reg[10].qneg[i]   <= wneg_reg[1] ^ side_reg[9].neg21[i] ^ wneg_reg[0];
            side_reg[10].qneg[3+i] <= wneg_reg[2] ^ side_reg[9].neg43[i] ^ wneg_reg[0];
        end
        side_reg[10].qneg[6] <= wneg_reg[1] ^ wneg_reg[0];
        side_reg[10].qneg[7] <= wneg_reg[2] ^ wneg_reg[0];
    end

    // ---------------------------------------------------------------------
    // Dividers: all eight share the divisor 2|denom|
    // ---------------------------------------------------------------------
    for (genvar g = 0; g < 8; g++)
    begin : g_div
        llcp_div #(
            .NW (NUM_DIV_W),
            .DW (DEN_DIV_W),
            .QW (QUO_W)
        ) u_div (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (vld_reg[13]),
            .num       (num_reg[g]),
            .den       (den13_reg),
            .out_valid (div_valid[g]),
            .quo       (div_quo[g]),
            .ovf       (div_ovf[g])
        );
    end

    // base plus signed quotient, saturated to Q16.16
    function automatic logic [CRD_W-1:0] sat_add(
        input logic signed [CRD_W-1:0] base,
        input logic [QUO_W-1:0]        q,
        input logic                    ovf,
        input logic                    neg
    );
        logic signed [SUM_W-1:0] qs;
        logic signed [SUM_W-1:0] sum;
        if (ovf)
        begin
            return neg ? SAT_MIN : SAT_MAX;
        end
        qs  = neg ? -$signed({2'b00, q}) : $signed({2'b00, q});
        sum = qs + SUM_W'(base);
        if (sum > SUM_MAX)
        begin
            return SAT_MAX;
        end
        if (sum < SUM_MIN)
        begin
            return SAT_MIN;
        end
        return CRD_W'(sum);
    endfunction

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            fin[i]   = sat_add($signed(side_reg[SIDE_LAST].base_a[i]), div_quo[i],
                               div_ovf[i], side_reg[SIDE_LAST].qneg[i]);
            fin[3+i] = sat_add($signed(side_reg[SIDE_LAST].base_b[i]), div_quo[3+i],
                               div_ovf[3+i], side_reg[SIDE_LAST].qneg[3+i]);
        end
        fin[6] = sat_add('0, div_quo[6], div_ovf[6], side_reg[SIDE_LAST].qneg[6]);
        fin[7] = sat_add('0, div_quo[7], div_ovf[7], side_reg[SIDE_LAST].qneg[7]);

        result_next.status   = side_reg[SIDE_LAST].status;
        result_next.near_a_x = fin[0];
        result_next.near_a_y = fin[1];
        result_next.near_a_z = fin[2];
        result_next.near_b_x = fin[3];
        result_next.near_b_y = fin[4];
        result_next.near_b_z = fin[5];
        result_next.param_a  = fin[6];
        result_next.param_b  = fin[7];
        // drop every value on a degenerate or parallel pair
        if (side_reg[SIDE_LAST].status != ST_OK)
        begin
            result_next          = '0;
            result_next.status   = side_reg[SIDE_LAST].status;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    a_fixed_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("accepted transfer did not complete after fixed latency");

    a_no_spurious_done: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("done without a matching accepted transfer");

    a_fail_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status != ST_OK) |->
            (result.near_a_x == 0 && result.near_a_y == 0 && result.near_a_z == 0 &&
             result.near_b_x == 0 && result.near_b_y == 0 && result.near_b_z == 0 &&
             result.param_a == 0 && result.param_b == 0))
        else $error("nonzero result values on a failed line pair");

endmodule

`default_nettype wire

// ===== rtl/core/llcp_div.sv =====
// Pipelined restoring divider: one quotient bit per stage, with overflow flag.
`default_nettype none

module llcp_div
    import llcp_pkg::*;
#(
    parameter int NW = NUM_DIV_W,
    parameter int DW = DEN_DIV_W,
    parameter int QW = QUO_W
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    input  wire logic [NW-1:0] num,
    input  wire logic [DW-1:0] den,
    output logic               out_valid,
    output logic [QW-1:0]      quo,
    output logic               ovf
);

    logic [QW:0]    v_reg;
    logic [NW-1:0]  rem_reg [QW];
    logic [DW-1:0]  den_reg [QW];
    logic [QW-1:0]  q_reg   [QW+1];
    logic           ovf_reg [QW+1];
    logic [NW-1:0]  lim;
    logic [NW-1:0]  trial   [1:QW];
    logic           fit     [1:QW];

    // quotient of 2^QW or more cannot be represented
    assign lim = NW'({den, {QW{1'b0}}});

    always_comb
    begin
        for (int j = 1; j <= QW; j++)
        begin
            trial[j] = NW'(den_reg[j-1]) << (QW - j);
            fit[j]   = rem_reg[j-1] >= trial[j];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= {v_reg[QW-1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0] <= num;
        den_reg[0] <= den;
        q_reg[0]   <= '0;
        ovf_reg[0] <= num >= lim;
        for (int j = 1; j <= QW; j++)
        begin
            q_reg[j]        <= q_reg[j-1] | (QW'(fit[j]) << (QW - j));
            ovf_reg[j]      <= ovf_reg[j-1];
            if (j < QW)
            begin
                rem_reg[j] <= fit[j] ? rem_reg[j-1] - trial[j] : rem_reg[j-1];
                den_reg[j] <= den_reg[j-1];
            end
        end
    end

    assign out_valid = v_reg[QW];
    assign quo       = q_reg[QW];
    assign ovf       = ovf_reg[QW];

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
// Self-checking bench for the closest-points-between-two-lines pipeline.
`default_nettype none

module tb_top;
    import llcp_pkg::*;

    localparam int WIDE_W     = 320;
    localparam int IDLE_LIMIT = 4000;
    localparam int DRAIN_CYC  = 60;
    localparam int N_RANDOM   = 900;

    typedef logic signed [WIDE_W-1:0] wide_t;

    // One directed row: stimulus plus an optional hand-typed expectation.
    typedef struct {
        item_t   pair;
        bit      typed;
        result_t want;
    } line_case_t;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    item_t                item;
    logic                 done;
    result_t              result;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [EPS_W-1:0]     cfg_data;

    // Local copy of the two epsilon registers.
    logic [EPS_W-1:0] coord_eps_q;
    logic [EPS_W-1:0] denom_eps_q;

    result_t    pending_results[$];
    line_case_t typed_checks[$];
    int         mismatch_count;
    int         idle_cycles;
    line_case_t directed[$];

    line_line_closest_points uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic wide_t wabs(wide_t v);
        return (v < 0) ? -v : v;
    endfunction

    // Quotient rounded to nearest, ties away from zero.
    function automatic wide_t div_nearest(wide_t n, wide_t d);
        wide_t q;
        q = ((wabs(n) <<< 1) + wabs(d)) / (wabs(d) <<< 1);
        return ((n < 0) != (d < 0)) ? -q : q;
    endfunction

    function automatic logic signed [CRD_W-1:0] sat_q16(wide_t v);
        if (v > wide_t'(32'sh7FFF_FFFF))
            return 32'sh7FFF_FFFF;
        if (v < -wide_t'(64'sh8000_0000))
            return 32'sh8000_0000;
        return v[CRD_W-1:0];
    endfunction

    function automatic bit below_eps(wide_t d[3], logic [EPS_W-1:0] eps);
        wide_t e;
        e = wide_t'({1'b0, eps});
        return wabs(d[0]) < e && wabs(d[1]) < e && wabs(d[2]) < e;
    endfunction

    function automatic wide_t dot3(wide_t a[3], wide_t b[3]);
        return a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
    endfunction

    // Predict the closest points for one line pair under the current epsilons.
    function automatic result_t closest_points(item_t it, logic [EPS_W-1:0] ceps,
                                               logic [EPS_W-1:0] deps);
        wide_t   p1[3], p2[3], p3[3], p4[3], p13[3], p43[3], p21[3];
        wide_t   d1343, d4321, d1321, d4343, d2121, den, na, nb, thr;
        result_t r;
        r = '0;
        p1[0] = wide_t'(it.first_start_x);  p1[1] = wide_t'(it.first_start_y);
        p1[2] = wide_t'(it.first_start_z);
        p2[0] = wide_t'(it.first_end_x);    p2[1] = wide_t'(it.first_end_y);
        p2[2] = wide_t'(it.first_end_z);
        p3[0] = wide_t'(it.second_start_x); p3[1] = wide_t'(it.second_start_y);
        p3[2] = wide_t'(it.second_start_z);
        p4[0] = wide_t'(it.second_end_x);   p4[1] = wide_t'(it.second_end_y);
        p4[2] = wide_t'(it.second_end_z);
        for (int i = 0; i < 3; i++)
        begin
            p13[i] = p1[i] - p3[i];
            p43[i] = p4[i] - p3[i];
            p21[i] = p2[i] - p1[i];
        end
        if (below_eps(p43, ceps))
        begin
            r.status = ST_B_DEGEN;
            return r;
        end
        if (below_eps(p21, ceps))
        begin
            r.status = ST_A_DEGEN;
            return r;
        end
        d1343 = dot3(p13, p43);
        d4321 = dot3(p43, p21);
        d1321 = dot3(p13, p21);
        d4343 = dot3(p43, p43);
        d2121 = dot3(p21, p21);
        den = d2121 * d4343 - d4321 * d4321;
        thr = wide_t'({1'b0, deps}) <<< DEN_EPS_SHIFT;
        if (den == 0 || wabs(den) < thr)
        begin
            r.status = ST_PARALLEL;
            return r;
        end
        na = d1343 * d4321 - d1321 * d4343;
        nb = d1343 * d2121 - d4321 * d1321;
        r.status   = ST_OK;
        r.near_a_x = sat_q16(p1[0] + div_nearest(na * p21[0], den));
        r.near_a_y = sat_q16(p1[1] + div_nearest(na * p21[1], den));
        r.near_a_z = sat_q16(p1[2] + div_nearest(na * p21[2], den));
        r.near_b_x = sat_q16(p3[0] + div_nearest(nb * p43[0], den));
        r.near_b_y = sat_q16(p3[1] + div_nearest(nb * p43[1], den));
        r.near_b_z = sat_q16(p3[2] + div_nearest(nb * p43[2], den));
        r.param_a  = sat_q16(div_nearest(na <<< 16, den));
        r.param_b  = sat_q16(div_nearest(nb <<< 16, den));
        return r;
    endfunction

    task automatic report_mismatch(string field, logic [CRD_W-1:0] got,
                                   logic [CRD_W-1:0] want);
        $display("mismatch %s: got %h want %h", field, got, want);
        mismatch_count++;
    endtask

    // Monitor: every transfer is sampled at the rising edge, before the
    // block's own updates land, so nothing hangs on event order.
    always @(posedge clk)
    begin
        line_case_t tc;
        result_t    want;
        if (rst_n)
        begin
            idle_cycles++;
            if (cfg_valid && cfg_ready)
            begin
                idle_cycles = 0;
                if (cfg_index == CFG_COORD_EPS)
                    coord_eps_q = cfg_data;
                else if (cfg_index == CFG_DENOM_EPS)
                    denom_eps_q = cfg_data;
            end
            if (start && !busy)
            begin
                idle_cycles = 0;
                tc = typed_checks.pop_front();
                if (tc.typed)
                    pending_results.push_back(tc.want);
                else
                    pending_results.push_back(closest_points(tc.pair, coord_eps_q,
                                                             denom_eps_q));
            end
            if (done)
            begin
                idle_cycles = 0;
                if (pending_results.size() == 0)
                begin
                    $display("unexpected result, status %0d", result.status);
                    mismatch_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (result.status !== want.status)
                        report_mismatch("status", 32'(result.status), 32'(want.status));
                    if (result.near_a_x !== want.near_a_x)
                        report_mismatch("near_a_x", result.near_a_x, want.near_a_x);
                    if (result.near_a_y !== want.near_a_y)
                        report_mismatch("near_a_y", result.near_a_y, want.near_a_y);
                    if (result.near_a_z !== want.near_a_z)
                        report_mismatch("near_a_z", result.near_a_z, want.near_a_z);
                    if (result.near_b_x !== want.near_b_x)
                        report_mismatch("near_b_x", result.near_b_x, want.near_b_x);
                    if (result.near_b_y !== want.near_b_y)
                        report_mismatch("near_b_y", result.near_b_y, want.near_b_y);
                    if (result.near_b_z !== want.near_b_z)
                        report_mismatch("near_b_z", result.near_b_z, want.near_b_z);
                    if (result.param_a !== want.param_a)
                        report_mismatch("param_a", result.param_a, want.param_a);
                    if (result.param_b !== want.param_b)
                        report_mismatch("param_b", result.param_b, want.param_b);
                end
            end
            // Drop the run if nothing moves for far longer than the pipeline depth.
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    function automatic item_t make_pair(logic signed [CRD_W-1:0] a[3],
                                        logic signed [CRD_W-1:0] b[3],
                                        logic signed [CRD_W-1:0] c[3],
                                        logic signed [CRD_W-1:0] d[3]);
        item_t it;
        it.first_start_x  = a[0]; it.first_start_y  = a[1]; it.first_start_z  = a[2];
        it.first_end_x    = b[0]; it.first_end_y    = b[1]; it.first_end_z    = b[2];
        it.second_start_x = c[0]; it.second_start_y = c[1]; it.second_start_z = c[2];
        it.second_end_x   = d[0]; it.second_end_y   = d[1]; it.second_end_z   = d[2];
        return it;
    endfunction

    function automatic logic signed [CRD_W-1:0] rand_coord();
        case ($urandom_range(0, 3))
            0:       return $urandom;
            1:       return $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
            2:       return ($urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000)
                            ^ 32'($urandom_range(0, 255));
            default: return $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
        endcase
    endfunction

    // Random pair: mostly well-formed lines, some parallel, some degenerate.
    function automatic item_t random_pair();
        logic signed [CRD_W-1:0] a[3], b[3], c[3], d[3], dir[3];
        int kind, k;
        kind = $urandom_range(0, 19);
        k    = $urandom_range(1, 4) * ($urandom_range(0, 1) ? 1 : -1);
        for (int i = 0; i < 3; i++)
        begin
            a[i]   = rand_coord();
            b[i]   = rand_coord();
            c[i]   = rand_coord();
            d[i]   = rand_coord();
            dir[i] = $signed($urandom_range(0, 32'h0002_0000)) - 32'sh0001_0000;
            if (kind == 0)
                d[i] = c[i] + $signed($urandom_range(0, 16)) - 8;
            else if (kind == 1)
                b[i] = a[i] + $signed($urandom_range(0, 16)) - 8;
            else if (kind < 5)
            begin
                b[i] = a[i] + dir[i];
                d[i] = c[i] + dir[i] * k + $signed($urandom_range(0, 2)) - 1;
            end
        end
        return make_pair(a, b, c, d);
    endfunction

    // Hold start and the pair until the transfer edge; keep start high when
    // the next pair follows without a gap.
    task automatic send_pair(item_t it, bit typed, result_t want);
        line_case_t tc;
        bit         taken;
        int         gap;
        tc.pair  = it;
        tc.typed = typed;
        tc.want  = want;
        typed_checks.push_back(tc);
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
        if ($urandom_range(0, 40) == 0)
            gap = $urandom_range(20, 70);
        if (gap > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            item  <= item_t'({$urandom, $urandom, $urandom, $urandom, $urandom,
                              $urandom, $urandom, $urandom, $urandom, $urandom,
                              $urandom, $urandom});
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        start <= 1'b1;
        item  <= it;
        do
        begin
            taken = !busy;
            @(posedge clk);
        end
        while (!taken);
    endtask

    // Drain the pipeline, then write one register while nothing is in flight.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [EPS_W-1:0] val);
        bit taken;
        @(negedge clk);
        start <= 1'b0;
        while (pending_results.size() != 0 || typed_checks.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYC) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
        begin
            taken = cfg_ready;
            @(posedge clk);
        end
        while (!taken);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic add_row(logic signed [CRD_W-1:0] a[3], logic signed [CRD_W-1:0] b[3],
                           logic signed [CRD_W-1:0] c[3], logic signed [CRD_W-1:0] d[3],
                           bit typed, logic [1:0] st);
        line_case_t row;
        row.pair  = make_pair(a, b, c, d);
        row.typed = typed;
        row.want  = '0;
        row.want.status = st;
        if (typed && st == ST_OK)
        begin
            row.want.near_a_x = a[0]; row.want.near_a_y = a[1]; row.want.near_a_z = a[2];
            row.want.near_b_x = c[0]; row.want.near_b_y = c[1]; row.want.near_b_z = c[2];
        end
        directed.push_back(row);
    endtask

    localparam logic signed [CRD_W-1:0] ONE  = 32'sh0001_0000;
    localparam logic signed [CRD_W-1:0] MAXC = 32'sh7FFF_FFFF;
    localparam logic signed [CRD_W-1:0] MINC = 32'sh8000_0000;

    initial
    begin
        logic [EPS_W-1:0] ceps_set[6];
        logic [EPS_W-1:0] deps_set[6];
        mismatch_count = 0;
        idle_cycles    = 0;
        coord_eps_q    = EPS_RESET;
        denom_eps_q    = EPS_RESET;
        rst_n     = 1'b0;
        start     = 1'b0;
        item      = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        // Directed rows: degenerate lines in check order, parallel lines,
        // thresholds right at the epsilon, perpendicular lines and extremes.
        add_row('{0, 0, 0}, '{0, 0, 0}, '{0, 0, 0}, '{0, 0, 0}, 1, ST_B_DEGEN);
        add_row('{0, 0, 0}, '{ONE, 0, 0}, '{ONE, ONE, 0}, '{ONE, ONE, 0}, 1, ST_B_DEGEN);
        add_row('{ONE, 0, 0}, '{ONE, 0, 0}, '{0, 0, 0}, '{0, ONE, 0}, 1, ST_A_DEGEN);
        add_row('{0, 0, 0}, '{6, -6, 6}, '{0, 0, 0}, '{-6, 6, 6}, 1, ST_B_DEGEN);
        add_row('{0, 0, 0}, '{6, 6, -6}, '{0, 0, 0}, '{7, 0, 0}, 1, ST_A_DEGEN);
        add_row('{0, 0, 0}, '{ONE, 0, 0}, '{0, ONE, 0}, '{2 * ONE, ONE, 0}, 1, ST_PARALLEL);
        add_row('{0, 0, 0}, '{ONE, 0, 0}, '{0, 0, ONE}, '{0, ONE, ONE}, 1, ST_OK);
        add_row('{0, 0, 0}, '{7, 0, 0}, '{0, 0, 0}, '{0, 7, 0}, 0, ST_OK);
        add_row('{MINC, MINC, MINC}, '{MAXC, MAXC, MAXC}, '{MAXC, MINC, 0},
                '{MINC, MAXC, 0}, 0, ST_OK);
        add_row('{MAXC, 0, MINC}, '{MINC, 0, MAXC}, '{0, MAXC, 0}, '{0, MINC, ONE}, 0, ST_OK);
        add_row('{MAXC, MAXC, MAXC}, '{MAXC - ONE, MAXC, MAXC}, '{MINC, MINC, MINC},
                '{MINC, MINC + ONE, MINC}, 0, ST_OK);
        add_row('{0, 0, 0}, '{ONE, 1, 0}, '{0, 5 * ONE, 0}, '{ONE, 5 * ONE, 1}, 0, ST_OK);
        add_row('{-ONE, 3 * ONE, 0}, '{ONE, 3 * ONE + 2, 7}, '{0, 0, 0},
                '{2 * ONE, 2, 7 * 2}, 0, ST_OK);
        add_row('{ONE, ONE, ONE}, '{-ONE, -ONE, 2 * ONE}, '{0, 0, -ONE},
                '{3 * ONE, -2 * ONE, ONE}, 0, ST_OK);
        foreach (directed[i])
            send_pair(directed[i].pair, directed[i].typed, directed[i].want);

        // Settings to cycle through, zero and full-scale among them.
        ceps_set = '{16'd0, 16'hFFFF, 16'd7, 16'd1, 16'd300, 16'd0};
        deps_set = '{16'd0, 16'hFFFF, 16'd0, 16'd1, 16'd40, 16'hFFFF};
        for (int ph = 0; ph < 7; ph++)
        begin
            if (ph > 0)
            begin
                write_reg(CFG_COORD_EPS, ph == 6 ? 16'($urandom) : ceps_set[ph - 1]);
                write_reg(CFG_DENOM_EPS, ph == 6 ? 16'($urandom) : deps_set[ph - 1]);
                // An index outside the register list must leave both alone.
                write_reg(8'($urandom_range(2, 255)), 16'($urandom));
            end
            // A zero denominator stays parallel even with a zero threshold.
            if (ph == 1)
                send_pair(make_pair('{0, 0, 0}, '{ONE, ONE, 0}, '{0, ONE, 0},
                                    '{ONE, 2 * ONE, 0}), 1, result_t'({ST_PARALLEL, 256'd0}));
            for (int n = 0; n < N_RANDOM / 7; n++)
                send_pair(random_pair(), 0, '0);
        end
        @(negedge clk);
        start <= 1'b0;

        // Wait for every result, then guard against stragglers.
        while (pending_results.size() != 0 || typed_checks.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYC) @(negedge clk);
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/core/llcp_pkg.sv
rtl/core/llcp_div.sv
rtl/core/line_line_closest_points.sv
bench/tb_top.sv
